// ===== rtl/ott_pkg.sv =====
// Shared types and constants for the obstacle track table.
// Item, result and table record layouts; field codes; saturation helper.
// No dependencies.
package ott_pkg;

	localparam int POS_W     = 24;
	localparam int TIME_W    = 32;
	localparam int COLOR_W   = 8;
	localparam int TYPE_W    = 3;
	localparam int IDX_W     = 5;
	localparam int KIND_W    = 3;
	localparam int ACT_W     = 2;
	localparam int HEAD_W    = 16;
	localparam int TRIG_W    = 18;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam int NHIT_W    = 6;

	localparam logic [ACT_W-1:0] ACT_POSE   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DETECT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REPORT = 2'd2;

	localparam logic [KIND_W-1:0] KIND_ADDED   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_UPDATED = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FULL    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_LOCAL   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NONE    = 3'd4;

	localparam logic [TYPE_W-1:0] TYPE_UNSET   = 3'd0;
	localparam logic [TYPE_W-1:0] TYPE_MARKER  = 3'd3;
	localparam logic [TYPE_W-1:0] TYPE_PICTURE = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_SEP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 2'd1;

	localparam logic [31:0] GATE_RESET   = 32'd16384;    // 128 squared
	localparam logic [31:0] RANGE_RESET  = 32'd6553600;  // 2560 squared
	localparam logic signed [TRIG_W-1:0] Q16_ONE = 18'sd65536;
	localparam logic [24:0] TAN1_Q24     = 25'd26128966;
	localparam logic [9:0]  VEL_SCALE    = 10'd1000;
	localparam logic [NHIT_W-1:0] MAX_RES = 6'd32;

	typedef struct packed {
		logic [ACT_W-1:0]          action;
		logic signed [POS_W-1:0]   pos_x;
		logic signed [POS_W-1:0]   pos_y;
		logic [HEAD_W-1:0]         heading;
		logic [TIME_W-1:0]         time_ms;
		logic [COLOR_W-1:0]        obj_color;
		logic [TYPE_W-1:0]         obj_type;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic [IDX_W-1:0]          entry_index;
		logic signed [POS_W-1:0]   out_x;
		logic signed [POS_W-1:0]   out_y;
		logic signed [POS_W-1:0]   vel_x;
		logic signed [POS_W-1:0]   vel_y;
		logic [COLOR_W-1:0]        out_color;
		logic [TYPE_W-1:0]         out_type;
		logic                      last;
	} result_t;

	typedef struct packed {
		logic signed [POS_W-1:0]   x;
		logic signed [POS_W-1:0]   y;
		logic signed [POS_W-1:0]   vx;
		logic signed [POS_W-1:0]   vy;
		logic [TIME_W-1:0]         seen;
		logic [COLOR_W-1:0]        color;
		logic [TYPE_W-1:0]         typ;
	} trk_rec_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0]  cos_v;
		logic signed [TRIG_W-1:0]  sin_v;
	} trig_t;

	function automatic logic signed [POS_W-1:0] sat24(input logic signed [27:0] v);
		if (v > 28'sd8388607)
			return 24'sd8388607;
		else if (v < -28'sd8388608)
			return -24'sd8388608;
		else
			return v[POS_W-1:0];
	endfunction

endpackage

// ===== rtl/obstacle_track_table_core.sv =====
// Pose: busy while the CORDIC runs. Detection: rotate states ROT1 and ROT2, then a table scan
// (one RAM read a cycle until a match or the end of the count); a match ends the scan and goes
// through PREP, then the 35-bit velocity divide unless the time step is zero, to UPD. Report:
// the scan gives one result per hit, up to 32, or one empty result. One item at a time; results
// show the cycle after they are formed; the receiver cannot stall them. Reset clears control,
// the pose, the track count and the config; table RAM is not cleared (never read past the count).
module obstacle_track_table_core
	import ott_pkg::*;
#(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  item_t                item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 result_valid,
	output result_t              result
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int CW    = $clog2(TABLE_DEPTH + 1);
	localparam int REC_W = $bits(trk_rec_t);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_CORDIC = 8'b0000_0010,
		ST_ROT1   = 8'b0000_0100,
		ST_ROT2   = 8'b0000_1000,
		ST_SCAN   = 8'b0001_0000,
		ST_PREP   = 8'b0010_0000,
		ST_DIV    = 8'b0100_0000,
		ST_UPD    = 8'b1000_0000
	} state_t;

	state_t state_q;
	item_t  in_q;
	logic signed [POS_W-1:0]  veh_x_q, veh_y_q, gx_q, gy_q;
	logic signed [TRIG_W-1:0] cos_q, sin_q;
	logic [31:0]    gate_q, range2_q;
	logic [CW-1:0]  count_q, rd_q;
	logic signed [41:0] rp1_q, rp2_q, rp3_q, rp4_q;

	// scan pipeline
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	trk_rec_t rec_s1, rec_s2, rec_s3, rec_s4, rec_s5;
	logic signed [24:0] ddx_s2, ddy_s2, rdx_s2, rdy_s2, ddx_s3, ddy_s3;
	logic signed [49:0] dx2_s3, dy2_s3;
	logic signed [42:0] pa_s3, pb_s3, pc_s3, pd_s3;
	logic signed [27:0] lx_s4, ly_s4;
	logic signed [16:0] lx_s5, ly_s5;
	logic        fit_s5, lxpos_s5;
	logic [31:0] lx2_s5, ly2_s5;
	logic [40:0] tanp_s5;
	logic [15:0] aly_s5;

	// match and output
	trk_rec_t m_rec_q;
	logic [AW-1:0] m_idx_q;
	logic signed [24:0] m_dx_q, m_dy_q;
	logic    dtz_q;
	result_t pend_q, res_q;
	logic    pend_v_q, res_v_q;
	logic [NHIT_W-1:0] nhit_q;

	// combinational
	logic accept, det_mode, in_scan, iss, keep, pipe_busy, scan_end, full;
	logic det_hit, rep_hit, rep_take;
	logic [50:0] sum_det;
	logic [32:0] r2;
	logic signed [42:0] sx, sy;
	logic signed [27:0] gsx, gsy;
	logic signed [43:0] lxs, lys;
	logic signed [33:0] lx_sq, ly_sq;
	logic signed [16:0] lx17, ly17;
	logic fitx, fity;
	logic [TYPE_W-1:0] typ_n;
	logic [TIME_W-1:0] dt;
	logic [24:0] mag_x, mag_y;
	logic [34:0] num_x, num_y, quo_x, quo_y;
	logic div_start, div_done, div_done_y;
	logic signed [POS_W-1:0] nvx, nvy;
	logic    emit;
	result_t emit_res, hit_res;
	logic    ram_we;
	logic [AW-1:0] ram_waddr;
	trk_rec_t ram_wrec;
	logic [REC_W-1:0] ram_rdata;
	logic cordic_start, cordic_done;
	trig_t cordic_trig;

	function automatic logic signed [POS_W-1:0] sat_vel(input logic [34:0] q, input logic neg);
		if (neg)
			return (q >= 35'd8388608) ? -24'sd8388608 : -$signed(q[POS_W-1:0]);
		else
			return (q >= 35'd8388608) ? 24'sd8388607 : $signed(q[POS_W-1:0]);
	endfunction

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign det_mode  = (in_q.action == ACT_DETECT);
	assign in_scan   = (state_q == ST_SCAN);
	assign full      = (count_q >= DEPTH_C);

	assign typ_n = (in_q.obj_type == TYPE_UNSET || in_q.obj_type > TYPE_PICTURE)
		? TYPE_MARKER : in_q.obj_type;

	// detection compare at stage 3
	assign sum_det = 51'(dx2_s3) + 51'(dy2_s3);
	assign det_hit = in_scan && det_mode && v_s3 && (sum_det < 51'(gate_q));

	// report compare at stage 5
	assign r2      = 33'(lx2_s5) + 33'(ly2_s5);
	assign rep_hit = in_scan && !det_mode && v_s5 && fit_s5 && lxpos_s5
		&& (r2 < 33'(range2_q)) && ({1'b0, aly_s5, 24'b0} < tanp_s5);
	assign rep_take = rep_hit && (nhit_q < MAX_RES);

	assign iss       = in_scan && (rd_q < count_q) && !det_hit;
	assign keep      = in_scan && !det_hit;
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign scan_end  = in_scan && (rd_q >= count_q) && !pipe_busy;
	assign rec_s1    = trk_rec_t'(ram_rdata);

	always_comb begin
		sx   = 43'(rp1_q) - 43'(rp2_q) + 43'sd32768;
		sy   = 43'(rp3_q) + 43'(rp4_q) + 43'sd32768;
		gsx  = 28'(veh_x_q) + 28'($signed(sx[42:16]));
		gsy  = 28'(veh_y_q) + 28'($signed(sy[42:16]));
		lxs  = 44'(pa_s3) + 44'(pb_s3) + 44'sd32768;
		lys  = 44'(pc_s3) - 44'(pd_s3) + 44'sd32768;
		lx17 = lx_s4[16:0];
		ly17 = ly_s4[16:0];
		fitx = (lx_s4 >= -28'sd65535) && (lx_s4 <= 28'sd65535);
		fity = (ly_s4 >= -28'sd65535) && (ly_s4 <= 28'sd65535);
		lx_sq = lx17 * lx17;
		ly_sq = ly17 * ly17;
	end

	// velocity divide operands
	always_comb begin
		dt    = in_q.time_ms - m_rec_q.seen;
		mag_x = m_dx_q[24] ? 25'(-m_dx_q) : 25'(m_dx_q);
		mag_y = m_dy_q[24] ? 25'(-m_dy_q) : 25'(m_dy_q);
		num_x = 35'(mag_x) * 35'(VEL_SCALE);
		num_y = 35'(mag_y) * 35'(VEL_SCALE);
		div_start = (state_q == ST_PREP) && (dt != '0);
		nvx = dtz_q ? m_rec_q.vx : sat_vel(quo_x, m_dx_q[24]);
		nvy = dtz_q ? m_rec_q.vy : sat_vel(quo_y, m_dy_q[24]);
	end

	always_comb begin
		hit_res.kind        = KIND_LOCAL;
		hit_res.entry_index = IDX_W'(idx_s5);
		hit_res.out_x       = {{(POS_W-17){lx_s5[16]}}, lx_s5};
		hit_res.out_y       = {{(POS_W-17){ly_s5[16]}}, ly_s5};
		hit_res.vel_x       = rec_s5.vx;
		hit_res.vel_y       = rec_s5.vy;
		hit_res.out_color   = rec_s5.color;
		hit_res.out_type    = rec_s5.typ;
		hit_res.last        = 1'b0;
	end

	// result selection and table writes
	always_comb begin
		emit      = 1'b0;
		emit_res  = '0;
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wrec.x     = gx_q;
		ram_wrec.y     = gy_q;
		ram_wrec.vx    = '0;
		ram_wrec.vy    = '0;
		ram_wrec.seen  = in_q.time_ms;
		ram_wrec.color = in_q.obj_color;
		ram_wrec.typ   = typ_n;
		if (state_q == ST_UPD) begin
			emit      = 1'b1;
			ram_we    = 1'b1;
			ram_waddr = m_idx_q;
			ram_wrec.vx    = nvx;
			ram_wrec.vy    = nvy;
			ram_wrec.color = m_rec_q.color;
			ram_wrec.typ   = m_rec_q.typ;
			emit_res.kind        = KIND_UPDATED;
			emit_res.entry_index = IDX_W'(m_idx_q);
			emit_res.out_x       = gx_q;
			emit_res.out_y       = gy_q;
			emit_res.vel_x       = nvx;
			emit_res.vel_y       = nvy;
			emit_res.out_color   = m_rec_q.color;
			emit_res.out_type    = m_rec_q.typ;
			emit_res.last        = 1'b1;
		end else if (scan_end && det_mode) begin
			emit = 1'b1;
			emit_res.kind      = full ? KIND_FULL : KIND_ADDED;
			emit_res.entry_index = full ? '0 : IDX_W'(count_q);
			emit_res.out_x     = gx_q;
			emit_res.out_y     = gy_q;
			emit_res.out_color = in_q.obj_color;
			emit_res.out_type  = typ_n;
			emit_res.last      = 1'b1;
			ram_we = !full;
		end else if (scan_end) begin
			emit = 1'b1;
			if (pend_v_q) begin
				emit_res      = pend_q;
				emit_res.last = 1'b1;
			end else begin
				emit_res.kind = KIND_NONE;
				emit_res.last = 1'b1;
			end
		end else if (rep_take && pend_v_q) begin
			emit     = 1'b1;
			emit_res = pend_q;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			veh_x_q  <= '0;
			veh_y_q  <= '0;
			cos_q    <= Q16_ONE;
			sin_q    <= '0;
			gate_q   <= GATE_RESET;
			range2_q <= RANGE_RESET;
			count_q  <= '0;
			rd_q     <= '0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			pend_v_q <= 1'b0;
			nhit_q   <= '0;
			res_v_q  <= 1'b0;
		end else begin
			res_v_q <= emit;
			v_s1 <= iss;
			v_s2 <= keep && v_s1;
			v_s3 <= keep && v_s2;
			v_s4 <= keep && v_s3;
			v_s5 <= keep && v_s4;
			if (iss)
				rd_q <= rd_q + 1'b1;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MIN_SEP:   gate_q   <= 32'(cfg_data) * 32'(cfg_data);
					REG_MAX_RANGE: range2_q <= 32'(cfg_data) * 32'(cfg_data);
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_q     <= '0;
						nhit_q   <= '0;
						pend_v_q <= 1'b0;
						priority if (item.action == ACT_POSE) begin
							veh_x_q <= item.pos_x;
							veh_y_q <= item.pos_y;
							state_q <= ST_CORDIC;
						end else if (item.action == ACT_DETECT)
							state_q <= ST_ROT1;
						else if (item.action == ACT_REPORT)
							state_q <= ST_SCAN;
						else
							state_q <= ST_IDLE;
					end
				end
				ST_CORDIC: begin
					if (cordic_done) begin
						cos_q   <= cordic_trig.cos_v;
						sin_q   <= cordic_trig.sin_v;
						state_q <= ST_IDLE;
					end
				end
				ST_ROT1: state_q <= ST_ROT2;
				ST_ROT2: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (det_hit)
						state_q <= ST_PREP;
					else if (scan_end) begin
						if (det_mode && !full)
							count_q <= count_q + 1'b1;
						state_q <= ST_IDLE;
					end else if (rep_take) begin
						pend_v_q <= 1'b1;
						nhit_q   <= nhit_q + 1'b1;
					end
				end
				ST_PREP: state_q <= (dt == '0) ? ST_UPD : ST_DIV;
				ST_DIV: begin
					if (div_done)
						state_q <= ST_UPD;
				end
				ST_UPD: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cordic_start = accept && (item.action == ACT_POSE);

	// datapath
	always_ff @(posedge clk) begin
		if (accept)
			in_q <= item;
		rp1_q <= in_q.pos_x * cos_q;
		rp2_q <= in_q.pos_y * sin_q;
		rp3_q <= in_q.pos_x * sin_q;
		rp4_q <= in_q.pos_y * cos_q;
		if (state_q == ST_ROT2) begin
			gx_q <= sat24(gsx);
			gy_q <= sat24(gsy);
		end

		idx_s1 <= rd_q[AW-1:0];
		idx_s2 <= idx_s1;
		rec_s2 <= rec_s1;
		ddx_s2 <= 25'(gx_q) - 25'(rec_s1.x);
		ddy_s2 <= 25'(gy_q) - 25'(rec_s1.y);
		rdx_s2 <= 25'(rec_s1.x) - 25'(veh_x_q);
		rdy_s2 <= 25'(rec_s1.y) - 25'(veh_y_q);

		idx_s3 <= idx_s2;
		rec_s3 <= rec_s2;
		ddx_s3 <= ddx_s2;
		ddy_s3 <= ddy_s2;
		dx2_s3 <= ddx_s2 * ddx_s2;
		dy2_s3 <= ddy_s2 * ddy_s2;
		pa_s3  <= rdx_s2 * cos_q;
		pb_s3  <= rdy_s2 * sin_q;
		pc_s3  <= rdy_s2 * cos_q;
		pd_s3  <= rdx_s2 * sin_q;

		idx_s4 <= idx_s3;
		rec_s4 <= rec_s3;
		lx_s4  <= lxs[43:16];
		ly_s4  <= lys[43:16];

		idx_s5   <= idx_s4;
		rec_s5   <= rec_s4;
		lx_s5    <= lx17;
		ly_s5    <= ly17;
		fit_s5   <= fitx && fity;
		lxpos_s5 <= !lx_s4[27] && (lx_s4 != '0);
		lx2_s5   <= lx_sq[31:0];
		ly2_s5   <= ly_sq[31:0];
		tanp_s5  <= 41'(TAN1_Q24) * 41'(lx_s4[15:0]);
		aly_s5   <= ly_s4[27] ? 16'(-ly_s4) : ly_s4[15:0];

		if (det_hit) begin
			m_rec_q <= rec_s3;
			m_idx_q <= idx_s3;
			m_dx_q  <= ddx_s3;
			m_dy_q  <= ddy_s3;
		end
		if (state_q == ST_PREP)
			dtz_q <= (dt == '0);
		if (rep_take)
			pend_q <= hit_res;
		res_q <= emit_res;
	end

	ott_ram #(
		.WIDTH (REC_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (REC_W'(ram_wrec)),
		.raddr (rd_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	ott_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cordic_start),
		.heading (item.heading),
		.done    (cordic_done),
		.trig    (cordic_trig)
	);

	ott_div #(
		.NUM_W (35),
		.DEN_W (TIME_W)
	) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_x),
		.den    (dt),
		.done   (div_done),
		.quo    (quo_x)
	);

	ott_div #(
		.NUM_W (35),
		.DEN_W (TIME_W)
	) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_y),
		.den    (dt),
		.done   (div_done_y),
		.quo    (quo_y)
	);

	assign result_valid = res_v_q;
	assign result       = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("track count above table depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.action == ACT_POSE || item.action == ACT_DETECT
		|| item.action == ACT_REPORT) |=> busy)
		else $error("accepted item did not make the block busy");

	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_NONE |-> result.last)
		else $error("empty report result without last");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without an item in progress");

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		div_done == div_done_y)
		else $error("velocity dividers out of step");

endmodule

// ===== rtl/ott_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ott_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/ott_cordic.sv =====
// Iterative heading-to-cosine/sine unit, one CORDIC step per cycle.
// Depends on ott_pkg (trig_t, widths).
module ott_cordic
	import ott_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HEAD_W-1:0] heading,
	output logic              done,
	output trig_t             trig
);

	localparam int STEPS = 15;
	localparam logic [13:0] ANG [STEPS] = '{
		14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
		14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1, 14'd1
	};

	logic              busy_q, fin_q, done_q;
	logic [3:0]        step_q;
	logic signed [33:0] x_q, y_q;
	logic signed [16:0] z_q;
	logic [1:0]        quad_q;
	trig_t             trig_q;

	logic signed [33:0] xs, ys, xr, yr;
	logic signed [16:0] ang;
	logic signed [TRIG_W-1:0] c, s;
	trig_t             trig_nx;

	function automatic logic signed [TRIG_W-1:0] clamp_unit(input logic signed [33:0] v);
		if (v > 34'sd65536)
			return Q16_ONE;
		else if (v < -34'sd65536)
			return -Q16_ONE;
		else
			return v[TRIG_W-1:0];
	endfunction

	always_comb begin
		xs  = x_q >>> step_q;
		ys  = y_q >>> step_q;
		ang = $signed({3'b000, ANG[step_q]});
		xr  = (x_q + 34'sd8192) >>> 14;
		yr  = (y_q + 34'sd8192) >>> 14;
		c   = clamp_unit(xr);
		s   = clamp_unit(yr);
		unique case (quad_q)
			2'd0: begin trig_nx.cos_v = c;  trig_nx.sin_v = s;  end
			2'd1: begin trig_nx.cos_v = -s; trig_nx.sin_v = c;  end
			2'd2: begin trig_nx.cos_v = -c; trig_nx.sin_v = -s; end
			default: begin trig_nx.cos_v = s; trig_nx.sin_v = -c; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			fin_q  <= 1'b0;
			done_q <= fin_q;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == 4'(STEPS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= 34'sd652032874;
			y_q    <= '0;
			z_q    <= $signed({3'b000, heading[13:0]});
			quad_q <= heading[15:14];
		end else if (busy_q) begin
			if (!z_q[16]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end
		end
		if (fin_q)
			trig_q <= trig_nx;
	end

	assign done = done_q;
	assign trig = trig_q;

endmodule

// ===== rtl/ott_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module ott_div #(
	parameter int NUM_W = 35,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   rem_q, rem_sh, rem_nx;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic             ge;

	always_comb begin
		rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
